// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/umpq_pkg.sv =====
// ----------------------------------------------------------------------------
// umpq_pkg
// Shared codes, widths and control structs of the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package umpq_pkg;

  localparam int RANK_BITS = 30;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_POLL   = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_ABSENT = 2'd3;

  typedef struct packed {
    logic latch;
    logic cnt_clr;
    logic cnt_inc;
    logic clr_wr;
    logic rd_en;
    logic commit;
  } umpq_cmd_t;

  typedef struct packed {
    logic cnt_last;
  } umpq_sts_t;

endpackage

`default_nettype wire

// ===== rtl/umpq_ram.sv =====
// ----------------------------------------------------------------------------
// umpq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module umpq_ram #(
  parameter int WIDTH = 61,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/umpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// umpq_ctrl
// Sequencer: clearing pass, per-item table scan and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module umpq_ctrl
  import umpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire umpq_sts_t sts,
  output umpq_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch   = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/umpq_dp.sv =====
// ----------------------------------------------------------------------------
// umpq_dp
// Datapath: slot RAM, scan trackers (match, free, best) and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module umpq_dp
  import umpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 30
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire umpq_cmd_t            cmd,
  output umpq_sts_t                 sts,
  input  wire logic [1:0]           in_func,
  input  wire logic [KEY_BITS-1:0]  in_event_key,
  input  wire logic [RANK_BITS-1:0] in_event_rank,
  output logic                      out_strobe,
  output logic [KEY_BITS-1:0]       out_polled_key,
  output logic [1:0]                out_status
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int ENT_W = 1 + KEY_BITS + RANK_BITS;

  // entry layout: {active, key, rank}
  logic [IDX_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 rd_vld_r;
  logic [ENT_W-1:0]     rd_data;

  logic [1:0]           func_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [RANK_BITS-1:0] rank_r;

  logic                 match_vld_r;
  logic [IDX_W-1:0]     match_idx_r;
  logic                 free_vld_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic                 best_vld_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [KEY_BITS-1:0]  best_key_r;
  logic [RANK_BITS-1:0] best_rank_r;

  logic                 out_strobe_r;
  logic [KEY_BITS-1:0]  out_key_r;
  logic [1:0]           out_status_r;

  logic                 e_active;
  logic [KEY_BITS-1:0]  e_key;
  logic [RANK_BITS-1:0] e_rank;
  logic                 is_last;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;
  logic                 cm_wr;
  logic [IDX_W-1:0]     cm_idx;
  logic [ENT_W-1:0]     cm_data;
  logic [KEY_BITS-1:0]  cm_key;
  logic [1:0]           cm_status;

  assign e_active = rd_data[ENT_W-1];
  assign e_key    = rd_data[KEY_BITS+RANK_BITS-1:RANK_BITS];
  assign e_rank   = rd_data[RANK_BITS-1:0];
  assign is_last  = (cnt_r == IDX_W'(CAPACITY - 1));
  assign sts.cnt_last = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= is_last ? '0 : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (cmd.latch) begin
      func_r <= in_func;
      key_r  <= in_event_key;
      rank_r <= in_event_rank;
    end
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_vld_r <= 1'b0;
      free_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
    end else if (cmd.latch) begin
      match_vld_r <= 1'b0;
      free_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
    end else if (rd_vld_r) begin
      if (e_active && (e_key == key_r) && !match_vld_r) begin
        match_vld_r <= 1'b1;
        match_idx_r <= rd_idx_r;
      end
      if (!e_active && !free_vld_r) begin
        free_vld_r <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (e_active && (!best_vld_r || (e_rank > best_rank_r) ||
          ((e_rank == best_rank_r) && (e_key < best_key_r)))) begin
        best_vld_r  <= 1'b1;
        best_idx_r  <= rd_idx_r;
        best_key_r  <= e_key;
        best_rank_r <= e_rank;
      end
    end
  end

  // commit decode
  always_comb begin
    cm_wr     = 1'b0;
    cm_idx    = match_idx_r;
    cm_data   = {1'b1, key_r, rank_r};
    cm_key    = '0;
    cm_status = STAT_OK;
    unique case (func_r)
      FUNC_LOAD: begin
        if (match_vld_r) begin
          cm_wr = 1'b1;
        end else if (free_vld_r) begin
          cm_wr  = 1'b1;
          cm_idx = free_idx_r;
        end else begin
          cm_status = STAT_FULL;
        end
      end
      FUNC_UPDATE: begin
        if (match_vld_r) begin
          cm_wr = 1'b1;
        end else begin
          cm_status = STAT_ABSENT;
        end
      end
      FUNC_POLL: begin
        if (best_vld_r) begin
          cm_wr   = 1'b1;
          cm_idx  = best_idx_r;
          cm_data = {1'b0, best_key_r, best_rank_r};
          cm_key  = best_key_r;
        end else begin
          cm_status = STAT_EMPTY;
        end
      end
      default: begin
        cm_wr = 1'b0;
      end
    endcase
  end

  assign wr_en   = cmd.clr_wr | (cmd.commit & cm_wr);
  assign wr_addr = cmd.clr_wr ? cnt_r : cm_idx;
  assign wr_data = cmd.clr_wr ? '0 : cm_data;

  umpq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (cnt_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_key_r    <= cm_key;
      out_status_r <= cm_status;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_polled_key = out_key_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/updatable_max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// updatable_max_priority_queue
// Table of active events (key, rank) with load, update and poll-highest.
// ----------------------------------------------------------------------------
// Command channel: drive in_func, in_event_key, in_event_rank with start;
// the beat is taken at a rising edge with start high and busy low.
// Every beat yields one result beat: out_strobe is high for one cycle with
// out_polled_key and out_status. The receiver cannot stall the block.
// Each command scans all CAPACITY slots through one RAM read port, one slot
// per cycle, then passes a drain state for the read register and a commit
// state; busy stays high through the scan, drain and commit states.
// out_strobe is registered from the commit and rises in the same cycle that
// busy falls; a new command can be taken at the edge that ends the result
// beat, so the block takes no new command before it is through with the
// last. Poll picks the highest rank, then the smallest key.
// After reset the block runs a clearing pass over every slot of the slot
// RAM with busy high; the table is then empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module updatable_max_priority_queue
  import umpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 30
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_func,
  input  wire logic [KEY_BITS-1:0]  in_event_key,
  input  wire logic [RANK_BITS-1:0] in_event_rank,
  output logic                      out_strobe,
  output logic [KEY_BITS-1:0]       out_polled_key,
  output logic [1:0]                out_status
);

  umpq_cmd_t cmd;
  umpq_sts_t sts;

  umpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  umpq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_event_key   (in_event_key),
    .in_event_rank  (in_event_rank),
    .out_strobe     (out_strobe),
    .out_polled_key (out_polled_key),
    .out_status     (out_status)
  );

  `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  `ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `ASSERT_IMP(a_nokey_fail, clk, rst_n, out_strobe && out_status != STAT_OK, out_polled_key == '0)

endmodule

`default_nettype wire

// ===== bench/tb_updatable_max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_updatable_max_priority_queue
// Self-checking bench for the event table with load, update and poll-highest.
// A behavioral copy of the table predicts status and polled key for every
// accepted command beat. A monitor checks each result beat against the oldest
// prediction. Stimulus covers directed corner cases, a full-table cycle and
// random traffic with and without idle bursts on the command side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_updatable_max_priority_queue
  import umpq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 64;
  localparam int KEY_BITS    = 30;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  localparam logic [1:0]          FUNC_NOP = 2'd3;
  localparam logic [KEY_BITS-1:0] KEY_MAX  = '1;
  localparam logic [RANK_BITS-1:0] RANK_MAX = '1;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [1:0]          status;
  } outcome_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_func = FUNC_LOAD;
  logic [KEY_BITS-1:0]  in_event_key = '0;
  logic [RANK_BITS-1:0] in_event_rank = '0;
  logic                 out_strobe;
  logic [KEY_BITS-1:0]  out_polled_key;
  logic [1:0]           out_status;

  logic [KEY_BITS-1:0]  tbl_key    [SLOTS];
  logic [RANK_BITS-1:0] tbl_rank   [SLOTS];
  bit                   tbl_active [SLOTS];

  outcome_t pending_outcomes[$];
  int       mismatches  = 0;
  int       idle_cycles = 0;
  bit       idle_on     = 1'b0;

  updatable_max_priority_queue #(
    .CAPACITY (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_event_key   (in_event_key),
    .in_event_rank  (in_event_rank),
    .out_strobe     (out_strobe),
    .out_polled_key (out_polled_key),
    .out_status     (out_status)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // behavioral table: returns the result of one command and updates state
  function automatic outcome_t predict_queue_op(input logic [1:0] f,
                                                input logic [KEY_BITS-1:0] k,
                                                input logic [RANK_BITS-1:0] r);
    outcome_t o;
    int       hit;
    int       free_slot;
    int       best;
    o.key     = '0;
    o.status  = STAT_OK;
    hit       = -1;
    free_slot = -1;
    best      = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_active[i] && tbl_key[i] == k && hit < 0) hit = i;
      if (!tbl_active[i] && free_slot < 0) free_slot = i;
    end
    case (f)
      FUNC_LOAD: begin
        if (hit >= 0) begin
          tbl_rank[hit] = r;
        end else if (free_slot < 0) begin
          o.status = STAT_FULL;
        end else begin
          tbl_key[free_slot]    = k;
          tbl_rank[free_slot]   = r;
          tbl_active[free_slot] = 1'b1;
        end
      end
      FUNC_UPDATE: begin
        if (hit < 0) o.status = STAT_ABSENT;
        else tbl_rank[hit] = r;
      end
      FUNC_POLL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_active[i] && (best < 0 || tbl_rank[i] > tbl_rank[best] ||
              (tbl_rank[i] == tbl_rank[best] && tbl_key[i] < tbl_key[best])))
            best = i;
        end
        if (best < 0) begin
          o.status = STAT_EMPTY;
        end else begin
          o.key = tbl_key[best];
          tbl_active[best] = 1'b0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int active_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += tbl_active[i];
    return n;
  endfunction

  function automatic logic [KEY_BITS-1:0] rand_key();
    logic [KEY_BITS-1:0] k;
    if ($urandom_range(0, 9) < 7) k = KEY_BITS'($urandom_range(0, 47));
    else k = KEY_BITS'($urandom());
    return k;
  endfunction

  function automatic logic [RANK_BITS-1:0] rand_rank();
    logic [RANK_BITS-1:0] r;
    if ($urandom_range(0, 1) == 0) r = RANK_BITS'($urandom_range(0, 7));
    else r = RANK_BITS'($urandom());
    return r;
  endfunction

  // key of a random live entry, or a random key if the table is empty
  function automatic logic [KEY_BITS-1:0] pick_active_key();
    int n;
    int sel;
    n = active_slots();
    if (n == 0) return rand_key();
    sel = $urandom_range(0, n - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_active[i]) begin
        if (sel == 0) return tbl_key[i];
        sel--;
      end
    end
    return rand_key();
  endfunction

  function automatic void flag_error(input string msg);
    if (mismatches < MAX_REPORTS) $display("ERROR: %s", msg);
    mismatches++;
  endfunction

  task automatic send_command(input logic [1:0] f, input logic [KEY_BITS-1:0] k,
                              input logic [RANK_BITS-1:0] r);
    @(negedge clk);
    start         = 1'b1;
    in_func       = f;
    in_event_key  = k;
    in_event_rank = r;
    do @(posedge clk); while (busy !== 1'b0);
    pending_outcomes.push_back(predict_queue_op(f, k, r));
  endtask

  // random idle burst, sometimes lined up with the end of busy
  task automatic maybe_idle();
    int n;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 11);
      @(negedge clk);
      start         = 1'b0;
      in_func       = 2'($urandom());
      in_event_key  = KEY_BITS'($urandom());
      in_event_rank = RANK_BITS'($urandom());
      if ($urandom_range(0, 1) == 1)
        while (busy !== 1'b0) @(negedge clk);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_corners();
    send_command(FUNC_POLL, KEY_MAX, RANK_MAX);
    send_command(FUNC_UPDATE, 30'd5, 30'd9);
    send_command(FUNC_NOP, KEY_MAX, RANK_MAX);
    send_command(FUNC_LOAD, '0, '0);
    send_command(FUNC_LOAD, KEY_MAX, RANK_MAX);
    send_command(FUNC_LOAD, 30'd1, RANK_MAX);
    send_command(FUNC_LOAD, 30'd1, 30'd7);
    send_command(FUNC_UPDATE, '0, RANK_MAX);
    send_command(FUNC_LOAD, 30'h2AAA_AAAA, 30'h1555_5555);
    send_command(FUNC_LOAD, 30'h1555_5555, 30'h2AAA_AAAA);
    send_command(FUNC_NOP, '0, '0);
    send_command(FUNC_UPDATE, KEY_MAX, 30'd7);
    repeat (6) send_command(FUNC_POLL, '0, '0);
    send_command(FUNC_UPDATE, 30'd1, 30'd3);
  endtask

  task automatic test_fill_to_capacity();
    while (active_slots() < SLOTS) begin
      maybe_idle();
      send_command(FUNC_LOAD, KEY_BITS'($urandom()), rand_rank());
    end
    send_command(FUNC_LOAD, pick_active_key(), rand_rank());
    send_command(FUNC_LOAD, KEY_BITS'($urandom()), rand_rank());
    send_command(FUNC_UPDATE, KEY_BITS'($urandom()), rand_rank());
    repeat (4) send_command(FUNC_UPDATE, pick_active_key(), rand_rank());
    repeat (SLOTS + 1) begin
      maybe_idle();
      send_command(FUNC_POLL, KEY_BITS'($urandom()), RANK_BITS'($urandom()));
    end
  endtask

  task automatic test_random_mix(input int count);
    int sel;
    repeat (count) begin
      maybe_idle();
      sel = $urandom_range(0, 99);
      if (sel < 40)
        send_command(FUNC_LOAD, rand_key(), rand_rank());
      else if (sel < 65)
        send_command(FUNC_UPDATE, ($urandom_range(0, 4) != 0) ? pick_active_key() :
                     rand_key(), rand_rank());
      else if (sel < 95)
        send_command(FUNC_POLL, KEY_BITS'($urandom()), RANK_BITS'($urandom()));
      else
        send_command(FUNC_NOP, rand_key(), rand_rank());
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        flag_error($sformatf("unexpected result beat key=%h status=%0d",
                             out_polled_key, out_status));
      end else begin
        want = pending_outcomes.pop_front();
        if (out_polled_key !== want.key || out_status !== want.status)
          flag_error($sformatf("key exp=%h act=%h, status exp=%0d act=%0d",
                               want.key, out_polled_key, want.status, out_status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    wait_all_results();

    idle_on = 1'b1;
    test_random_mix(300);
    wait_all_results();
    test_fill_to_capacity();
    wait_all_results();

    idle_on = 1'b0;
    test_random_mix(200);
    wait_all_results();

    repeat (SLOTS + 8) @(posedge clk);
    if (pending_outcomes.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
